[rtl/jpfr_pkg.sv]
// shared types, constants and the crc byte step of the pwm frame receiver
`default_nettype none

package jpfr_pkg;

    // parameter defaults
    localparam int MAX_FRAME_BYTES_DEF = 16;
    localparam int DURATION_BITS_DEF   = 15;

    // configuration port
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PULSE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PULSE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_THRESH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SYMBOLS = 3'd4;

    // register reset values
    localparam logic [7:0]  SHORT_PULSE_RST = 8'd8;
    localparam logic [7:0]  LONG_PULSE_RST  = 8'd16;
    localparam logic [7:0]  TOLERANCE_RST   = 8'd4;
    localparam logic [14:0] END_THRESH_RST  = 15'd24;
    localparam logic [7:0]  MIN_SYMBOLS_RST = 8'd8;

    // crc-8
    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    // record kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // result queue depth, room for two words per symbol plus slack
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  short_pulse_ticks;
        logic [7:0]  long_pulse_ticks;
        logic [7:0]  pulse_tolerance;
        logic [14:0] end_threshold;
        logic [7:0]  min_symbols;
    } cfg_t;

    typedef struct packed {
        logic       record_kind;
        logic [7:0] data_byte;
        logic [3:0] byte_position;
        logic [4:0] frame_length;
        logic       frame_accepted;
        logic       checksum_ok;
        logic       last;
    } rec_t;

    // words handed from the decoder to the result queue, rec_a goes first
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec_a;
        rec_t       rec_b;
    } push_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/jpfr_if.sv]
// valid/ready channels for pulse symbols and result records
`default_nettype none

interface jpfr_sym_if #(
    parameter int DURATION_BITS = jpfr_pkg::DURATION_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [DURATION_BITS-1:0] high_ticks;
    logic [DURATION_BITS-1:0] low_ticks;
    logic                     last_symbol;

    modport source (output valid, output high_ticks, output low_ticks,
                    output last_symbol, input ready);
    modport sink   (input valid, input high_ticks, input low_ticks,
                    input last_symbol, output ready);
endinterface

interface jpfr_rec_if;
    logic       valid;
    logic       ready;
    logic       record_kind;
    logic [7:0] data_byte;
    logic [3:0] byte_position;
    logic [4:0] frame_length;
    logic       frame_accepted;
    logic       checksum_ok;
    logic       last;

    modport source (output valid, output record_kind, output data_byte,
                    output byte_position, output frame_length,
                    output frame_accepted, output checksum_ok, output last,
                    input ready);
    modport sink   (input valid, input record_kind, input data_byte,
                    input byte_position, input frame_length,
                    input frame_accepted, input checksum_ok, input last,
                    output ready);
endinterface

`default_nettype wire

[rtl/j1850_pwm_frame_receiver_core.sv]
// top level of the j1850 pwm frame receiver
`default_nettype none

// Takes one measured pulse symbol per word on sym and gives data-byte and
// end-of-frame words on rec. A symbol is registered on acceptance and
// decoded from that register while the queue has room, so one symbol per
// clock is sustained while the output side takes words as fast as they
// come. Each symbol yields zero, one or two words (a byte completed by the
// capture's last symbol gives the data word, then the frame word); words
// wait in a four-entry queue, and a symbol is decoded only while the queue
// has two free entries, so a run of two-word symbols is paced by the single
// output channel at one word per clock while rec.ready is high. Words reach
// rec through the input register and the result queue. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and should change
// only while no symbol is in flight. No clearing pass follows reset.
module j1850_pwm_frame_receiver_core #(
    parameter int MAX_FRAME_BYTES = jpfr_pkg::MAX_FRAME_BYTES_DEF,
    parameter int DURATION_BITS   = jpfr_pkg::DURATION_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [jpfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jpfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    jpfr_sym_if.sink                              sym,
    jpfr_rec_if.source                            rec
);

    jpfr_pkg::cfg_t  cfg;
    jpfr_pkg::push_t push;
    logic            room;
    logic [$clog2(jpfr_pkg::FIFO_DEPTH):0] level;

    // configuration registers
    jpfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // symbol decode
    jpfr_decoder #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .DURATION_BITS   (DURATION_BITS)
    ) u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    // result queue
    jpfr_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .level (level),
        .rec   (rec)
    );

`ifndef SYNTH
    // words are only pushed while two entries are free
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (level <= ($clog2(jpfr_pkg::FIFO_DEPTH) + 1)'(jpfr_pkg::FIFO_DEPTH - 2)))
        else $error("result pushed without room in queue");

    // a two-word symbol is a data word followed by a frame word
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.rec_a.record_kind == jpfr_pkg::KIND_DATA &&
                                !push.rec_a.last &&
                                push.rec_b.record_kind == jpfr_pkg::KIND_FRAME))
        else $error("two-word symbol out of order");

    // a frame word always closes its symbol
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rec.valid && rec.record_kind == jpfr_pkg::KIND_FRAME) |-> rec.last)
        else $error("frame word without last");

    // push count never exceeds two
    a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd3)
        else $error("illegal push count");
`endif

endmodule

`default_nettype wire

[rtl/jpfr_cfg_regs.sv]
// configuration registers of the pwm frame receiver
`default_nettype none

module jpfr_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [jpfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [jpfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output jpfr_pkg::cfg_t                            cfg
);

    jpfr_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_pulse_ticks <= jpfr_pkg::SHORT_PULSE_RST;
            cfg_reg.long_pulse_ticks  <= jpfr_pkg::LONG_PULSE_RST;
            cfg_reg.pulse_tolerance   <= jpfr_pkg::TOLERANCE_RST;
            cfg_reg.end_threshold     <= jpfr_pkg::END_THRESH_RST;
            cfg_reg.min_symbols       <= jpfr_pkg::MIN_SYMBOLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jpfr_pkg::REG_SHORT_PULSE: cfg_reg.short_pulse_ticks <= cfg_data[7:0];
                jpfr_pkg::REG_LONG_PULSE:  cfg_reg.long_pulse_ticks  <= cfg_data[7:0];
                jpfr_pkg::REG_TOLERANCE:   cfg_reg.pulse_tolerance   <= cfg_data[7:0];
                jpfr_pkg::REG_END_THRESH:  cfg_reg.end_threshold     <= cfg_data[14:0];
                jpfr_pkg::REG_MIN_SYMBOLS: cfg_reg.min_symbols       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/jpfr_decoder.sv]
// symbol input register, bit and byte assembly, crc and frame state
`default_nettype none

module jpfr_decoder #(
    parameter int MAX_FRAME_BYTES = jpfr_pkg::MAX_FRAME_BYTES_DEF,
    parameter int DURATION_BITS   = jpfr_pkg::DURATION_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    jpfr_sym_if.sink             sym,
    input  wire jpfr_pkg::cfg_t  cfg,
    input  wire logic            room,
    output jpfr_pkg::push_t      push
);

    // window compare width holds duration plus tolerance without wrap
    localparam int WW = ((DURATION_BITS > 8) ? DURATION_BITS : 8) + 1;
    // end threshold compare width
    localparam int TW = (DURATION_BITS > 15) ? DURATION_BITS : 15;
    localparam logic [4:0] MAX_BYTES = 5'(MAX_FRAME_BYTES);

    // input register
    logic                     hold_valid_reg;
    logic [DURATION_BITS-1:0] hold_high_reg;
    logic [DURATION_BITS-1:0] hold_low_reg;
    logic                     hold_last_reg;
    logic                     fire;

    // frame state
    logic [2:0] bit_count_reg,        bit_count_next;
    logic [7:0] shift_byte_reg,       shift_byte_next;
    logic [4:0] byte_count_reg,       byte_count_next;
    logic [8:0] symbol_count_reg,     symbol_count_next;
    logic       stopped_reg,          stopped_next;
    logic [7:0] crc_running_reg,      crc_running_next;
    logic [7:0] crc_before_last_reg,  crc_before_last_next;
    logic [7:0] last_stored_reg,      last_stored_next;

    logic [WW-1:0] d_ext, short_ext, long_ext, tol_ext;
    logic          is_one, is_zero, got;
    logic [7:0]    done_byte;
    logic          over_thresh;
    jpfr_pkg::rec_t data_rec, frame_rec;
    jpfr_pkg::push_t push_w;

    assign fire      = hold_valid_reg && room;
    assign sym.ready = !hold_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (sym.ready)
        begin
            hold_valid_reg <= sym.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym.valid && sym.ready)
        begin
            hold_high_reg <= sym.high_ticks;
            hold_low_reg  <= sym.low_ticks;
            hold_last_reg <= sym.last_symbol;
        end
    end

    // pulse classification, strict windows around nominal
    always_comb
    begin
        d_ext     = WW'(hold_high_reg);
        short_ext = WW'(cfg.short_pulse_ticks);
        long_ext  = WW'(cfg.long_pulse_ticks);
        tol_ext   = WW'(cfg.pulse_tolerance);
        is_one    = (d_ext + tol_ext > short_ext) && (d_ext < short_ext + tol_ext);
        is_zero   = (d_ext + tol_ext > long_ext) && (d_ext < long_ext + tol_ext);
        got       = is_one || is_zero;
        over_thresh = (TW'(hold_high_reg) > TW'(cfg.end_threshold)) ||
                      (TW'(hold_low_reg) > TW'(cfg.end_threshold));
    end

    // next frame state and the words this symbol produces
    always_comb
    begin
        bit_count_next       = bit_count_reg;
        shift_byte_next      = shift_byte_reg;
        byte_count_next      = byte_count_reg;
        stopped_next         = stopped_reg;
        crc_running_next     = crc_running_reg;
        crc_before_last_next = crc_before_last_reg;
        last_stored_next     = last_stored_reg;
        symbol_count_next    = (symbol_count_reg == 9'h1FF) ? symbol_count_reg
                                                            : symbol_count_reg + 9'd1;
        done_byte = shift_byte_reg | {7'd0, is_one};
        data_rec  = '0;
        frame_rec = '0;
        push_w    = '0;

        if (!stopped_reg && got)
        begin
            if (bit_count_reg == 3'd7)
            begin
                if (byte_count_reg < MAX_BYTES)
                begin
                    data_rec.record_kind   = jpfr_pkg::KIND_DATA;
                    data_rec.data_byte     = done_byte;
                    data_rec.byte_position = byte_count_reg[3:0];
                    data_rec.last          = !hold_last_reg;
                    push_w.cnt             = 2'd1;
                    push_w.rec_a           = data_rec;
                    crc_before_last_next   = crc_running_reg;
                    crc_running_next       = jpfr_pkg::crc_step(crc_running_reg, done_byte);
                    last_stored_next       = done_byte;
                    byte_count_next        = byte_count_reg + 5'd1;
                end
                bit_count_next  = 3'd0;
                shift_byte_next = 8'd0;
                if (over_thresh)
                begin
                    stopped_next = 1'b1;
                end
            end
            else
            begin
                bit_count_next = bit_count_reg + 3'd1;
                if (is_one)
                begin
                    shift_byte_next = shift_byte_reg | (8'h80 >> bit_count_reg);
                end
            end
        end

        // capture end: frame record, then a fresh frame
        if (hold_last_reg)
        begin
            frame_rec.record_kind    = jpfr_pkg::KIND_FRAME;
            frame_rec.frame_length   = byte_count_next;
            frame_rec.frame_accepted = symbol_count_next > {1'b0, cfg.min_symbols};
            frame_rec.checksum_ok    = (byte_count_next != 5'd0) &&
                (last_stored_next == (crc_before_last_next ^ jpfr_pkg::CRC_XOROUT));
            frame_rec.last           = 1'b1;
            if (push_w.cnt == 2'd1)
            begin
                push_w.rec_b = frame_rec;
                push_w.cnt   = 2'd2;
            end
            else
            begin
                push_w.rec_a = frame_rec;
                push_w.cnt   = 2'd1;
            end
            bit_count_next       = 3'd0;
            shift_byte_next      = 8'd0;
            byte_count_next      = 5'd0;
            symbol_count_next    = 9'd0;
            stopped_next         = 1'b0;
            crc_running_next     = jpfr_pkg::CRC_INIT;
            crc_before_last_next = jpfr_pkg::CRC_INIT;
            last_stored_next     = 8'd0;
        end

        push = push_w;
        if (!fire)
        begin
            push.cnt = 2'd0;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg       <= 3'd0;
            shift_byte_reg      <= 8'd0;
            byte_count_reg      <= 5'd0;
            symbol_count_reg    <= 9'd0;
            stopped_reg         <= 1'b0;
            crc_running_reg     <= jpfr_pkg::CRC_INIT;
            crc_before_last_reg <= jpfr_pkg::CRC_INIT;
            last_stored_reg     <= 8'd0;
        end
        else if (fire)
        begin
            bit_count_reg       <= bit_count_next;
            shift_byte_reg      <= shift_byte_next;
            byte_count_reg      <= byte_count_next;
            symbol_count_reg    <= symbol_count_next;
            stopped_reg         <= stopped_next;
            crc_running_reg     <= crc_running_next;
            crc_before_last_reg <= crc_before_last_next;
            last_stored_reg     <= last_stored_next;
        end
    end

endmodule

`default_nettype wire

[rtl/jpfr_out_fifo.sv]
// result queue taking up to two words a cycle and giving one while rec.ready is high
`default_nettype none

module jpfr_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire jpfr_pkg::push_t  push,
    output logic                  room,
    output logic [$clog2(jpfr_pkg::FIFO_DEPTH):0] level,
    jpfr_rec_if.source            rec
);

    localparam int DEPTH = jpfr_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = PW + 1;

    jpfr_pkg::rec_t mem [DEPTH];
    jpfr_pkg::rec_t head;
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop   = rec.valid && rec.ready;
    assign room  = count_reg <= CW'(DEPTH - 2);
    assign level = count_reg;

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.rec_a;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PW'(1)] <= push.rec_b;
        end
    end

    // pointers and fill level
    always_comb
    begin
        count_next = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

    // head word to the output channel
    assign head               = mem[rd_ptr_reg];
    assign rec.valid          = count_reg != '0;
    assign rec.record_kind    = head.record_kind;
    assign rec.data_byte      = head.data_byte;
    assign rec.byte_position  = head.byte_position;
    assign rec.frame_length   = head.frame_length;
    assign rec.frame_accepted = head.frame_accepted;
    assign rec.checksum_ok    = head.checksum_ok;
    assign rec.last           = head.last;

endmodule

`default_nettype wire

[sim/j1850_pwm_frame_receiver_core_tb.sv]
// self-checking testbench of the j1850 pwm frame receiver core
`timescale 1ns / 1ps

module j1850_pwm_frame_receiver_core_tb;

    localparam int MAX_BYTES   = jpfr_pkg::MAX_FRAME_BYTES_DEF;
    localparam int DUR_W       = jpfr_pkg::DURATION_BITS_DEF;
    localparam int DUR_MAX     = (1 << DUR_W) - 1;
    localparam logic [DUR_W-1:0] DUR_TOP = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // ways a generated frame can end
    typedef enum int {END_ON_BIT, END_TRAILER, END_STOP, END_PARTIAL} frame_end_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [jpfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [jpfr_pkg::CFG_DATA_W-1:0]  cfg_data;

    jpfr_sym_if #(.DURATION_BITS(DUR_W)) sym_ch ();
    jpfr_rec_if                          rec_ch ();

    j1850_pwm_frame_receiver_core #(
        .MAX_FRAME_BYTES(MAX_BYTES),
        .DURATION_BITS  (DUR_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sym      (sym_ch),
        .rec      (rec_ch)
    );

    // register copy and frame state of the decoder model
    jpfr_pkg::cfg_t cur_cfg;
    logic [2:0]  rx_bit_cnt;
    logic [7:0]  rx_shift;
    logic [4:0]  rx_bytes;
    logic [8:0]  rx_symbols;
    logic        rx_stopped;
    logic [7:0]  rx_crc;
    logic [7:0]  rx_crc_prev;
    logic [7:0]  rx_last_byte;

    jpfr_pkg::rec_t expected_records[$];
    jpfr_pkg::rec_t want_rec;
    int          error_count;
    int          cycle_count;
    int          pattern_symbols;
    bit          idle_en;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // crc-8 over one byte, msb first
    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            c = c[7] ? ((c << 1) ^ jpfr_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // strict window around nominal, no wrap below zero
    function automatic bit in_window(int d, int nominal, int tol);
        return (d + tol > nominal) && (d < nominal + tol);
    endfunction

    function automatic jpfr_pkg::cfg_t mk_cfg(int s, int l, int t, int e, int m);
        jpfr_pkg::cfg_t c;
        c.short_pulse_ticks = 8'(s);
        c.long_pulse_ticks  = 8'(l);
        c.pulse_tolerance   = 8'(t);
        c.end_threshold     = 15'(e);
        c.min_symbols       = 8'(m);
        return c;
    endfunction

    task automatic clear_frame_state();
        rx_bit_cnt   = '0;
        rx_shift     = '0;
        rx_bytes     = '0;
        rx_symbols   = '0;
        rx_stopped   = 1'b0;
        rx_crc       = jpfr_pkg::CRC_INIT;
        rx_crc_prev  = jpfr_pkg::CRC_INIT;
        rx_last_byte = '0;
    endtask

    // expected words for one accepted symbol
    task automatic decode_symbol(logic [DUR_W-1:0] h, logic [DUR_W-1:0] l, logic lst);
        jpfr_pkg::rec_t outs[2];
        int   n;
        bit   got;
        n = 0;
        if (rx_symbols != 9'h1FF)
            rx_symbols = rx_symbols + 9'd1;
        if (!rx_stopped)
        begin
            got = 1'b0;
            if (in_window(int'(h), int'(cur_cfg.short_pulse_ticks),
                          int'(cur_cfg.pulse_tolerance)))
            begin
                rx_shift = rx_shift | (8'h80 >> rx_bit_cnt);
                got = 1'b1;
            end
            else if (in_window(int'(h), int'(cur_cfg.long_pulse_ticks),
                               int'(cur_cfg.pulse_tolerance)))
            begin
                got = 1'b1;
            end
            if (got)
            begin
                if (rx_bit_cnt == 3'd7)
                begin
                    // bytes past the frame limit are dropped silently
                    if (int'(rx_bytes) < MAX_BYTES)
                    begin
                        outs[n] = '0;
                        outs[n].record_kind   = jpfr_pkg::KIND_DATA;
                        outs[n].data_byte     = rx_shift;
                        outs[n].byte_position = rx_bytes[3:0];
                        n++;
                        rx_crc_prev  = rx_crc;
                        rx_crc       = crc8_update(rx_crc, rx_shift);
                        rx_last_byte = rx_shift;
                        rx_bytes     = rx_bytes + 5'd1;
                    end
                    rx_bit_cnt = '0;
                    rx_shift   = '0;
                    if (int'(h) > int'(cur_cfg.end_threshold) ||
                        int'(l) > int'(cur_cfg.end_threshold))
                        rx_stopped = 1'b1;
                end
                else
                begin
                    rx_bit_cnt = rx_bit_cnt + 3'd1;
                end
            end
        end
        if (lst)
        begin
            outs[n] = '0;
            outs[n].record_kind    = jpfr_pkg::KIND_FRAME;
            outs[n].frame_length   = rx_bytes;
            outs[n].frame_accepted = (rx_symbols > {1'b0, cur_cfg.min_symbols});
            outs[n].checksum_ok    = (rx_bytes != 5'd0) &&
                                     (rx_last_byte == (rx_crc_prev ^ jpfr_pkg::CRC_XOROUT));
            n++;
            clear_frame_state();
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_records.push_back(outs[i]);
    endtask

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // write all registers, block must be idle
    task automatic write_config(jpfr_pkg::cfg_t c);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            case (i)
                0:
                begin
                    cfg_index <= jpfr_pkg::REG_SHORT_PULSE;
                    cfg_data  <= {7'd0, c.short_pulse_ticks};
                end
                1:
                begin
                    cfg_index <= jpfr_pkg::REG_LONG_PULSE;
                    cfg_data  <= {7'd0, c.long_pulse_ticks};
                end
                2:
                begin
                    cfg_index <= jpfr_pkg::REG_TOLERANCE;
                    cfg_data  <= {7'd0, c.pulse_tolerance};
                end
                3:
                begin
                    cfg_index <= jpfr_pkg::REG_END_THRESH;
                    cfg_data  <= c.end_threshold;
                end
                default:
                begin
                    cfg_index <= jpfr_pkg::REG_MIN_SYMBOLS;
                    cfg_data  <= {7'd0, c.min_symbols};
                end
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_cfg = c;
    endtask

    // one symbol word, with random idle before it while idle_en is set
    task automatic send_symbol(logic [DUR_W-1:0] h, logic [DUR_W-1:0] l, logic lst);
        while (idle_en && $urandom_range(99) < 11)
        begin
            sym_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.high_ticks  <= h;
        sym_ch.low_ticks   <= l;
        sym_ch.last_symbol <= lst;
        @(posedge clk);
        while (!sym_ch.ready)
            @(posedge clk);
        decode_symbol(h, l, lst);
    endtask

    // stop sending and let every expected word come out
    task automatic wait_idle();
        sym_ch.valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // high time strictly inside the window around nominal, or the nominal itself at zero tolerance
    function automatic logic [DUR_W-1:0] pick_high(int nominal);
        int tol;
        int lo;
        int hi;
        tol = int'(cur_cfg.pulse_tolerance);
        if (tol == 0)
            return DUR_W'(nominal);
        lo = nominal - tol + 1;
        if (lo < 0)
            lo = 0;
        hi = nominal + tol - 1;
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [DUR_W-1:0] pick_low(bit stop_now);
        int e;
        e = int'(cur_cfg.end_threshold);
        if (stop_now && e < DUR_MAX)
            return DUR_W'($urandom_range(DUR_MAX, e + 1));
        return DUR_W'($urandom_range(e, 0));
    endfunction

    function automatic logic [DUR_W-1:0] pick_bit(bit one);
        return one ? pick_high(int'(cur_cfg.short_pulse_ticks))
                   : pick_high(int'(cur_cfg.long_pulse_ticks));
    endfunction

    function automatic logic [DUR_W-1:0] pick_any();
        return DUR_W'($urandom_range(DUR_MAX, 0));
    endfunction

    // one well-formed frame with random content and a little noise
    task automatic send_frame(int nbytes, frame_end_t ending, bit fix_crc);
        logic [7:0] crc;
        logic [7:0] b;
        bit         final_bit;
        int         extra;
        crc = jpfr_pkg::CRC_INIT;
        for (int i = 0; i < nbytes; i++)
        begin
            b = 8'($urandom);
            if (fix_crc && i == nbytes - 1 && nbytes <= MAX_BYTES)
                b = crc ^ jpfr_pkg::CRC_XOROUT;
            crc = crc8_update(crc, b);
            for (int k = 7; k >= 0; k--)
            begin
                if ($urandom_range(99) < 5)
                    send_symbol(pick_any(), pick_any(), 1'b0);
                final_bit = (i == nbytes - 1) && (k == 0);
                send_symbol(pick_bit(b[k]), pick_low(final_bit && ending == END_STOP),
                            final_bit && ending == END_ON_BIT);
                pattern_symbols++;
            end
        end
        // closing symbols
        if (ending == END_STOP)
        begin
            extra = int'($urandom_range(4, 1));
            repeat (extra)
            begin
                send_symbol(pick_bit(1'($urandom_range(1))), pick_low(1'b0), 1'b0);
                pattern_symbols++;
            end
        end
        if (ending == END_PARTIAL)
        begin
            extra = int'($urandom_range(7, 1));
            for (int k = 0; k < extra; k++)
            begin
                send_symbol(pick_bit(1'($urandom_range(1))), pick_low(1'b0), k == extra - 1);
                pattern_symbols++;
            end
        end
        else if (ending != END_ON_BIT || nbytes == 0)
        begin
            send_symbol(pick_any(), pick_any(), 1'b1);
            pattern_symbols++;
        end
    endtask

    // window edges at reset settings, a stop, and symbols ignored after it
    task automatic test_window_edges();
        send_symbol(15'd4, 15'd0, 1'b0);
        send_symbol(15'd5, 15'd0, 1'b0);
        send_symbol(15'd11, 15'd0, 1'b0);
        send_symbol(15'd12, 15'd0, 1'b0);
        send_symbol(15'd13, 15'd0, 1'b0);
        send_symbol(15'd19, 15'd0, 1'b0);
        send_symbol(15'd20, 15'd0, 1'b0);
        send_symbol(DUR_TOP, DUR_TOP, 1'b0);
        send_symbol(15'd5, 15'd0, 1'b0);
        send_symbol(15'd13, 15'd0, 1'b0);
        send_symbol(15'd5, 15'd0, 1'b0);
        send_symbol(15'd13, DUR_TOP, 1'b0);
        send_symbol(15'd5, 15'd0, 1'b1);
        wait_idle();
    endtask

    // empty frame, then one byte that ends the capture on its last bit
    task automatic test_short_frames();
        send_symbol(15'd0, 15'd0, 1'b1);
        for (int k = 0; k < 8; k++)
            send_symbol(15'd16, 15'd1, k == 7);
        wait_idle();
    endtask

    // nominal below tolerance, register extremes
    task automatic test_config_extremes();
        write_config(mk_cfg(2, 255, 5, DUR_MAX, 0));
        send_symbol(15'd0, 15'd0, 1'b0);
        send_symbol(15'd255, 15'd0, 1'b0);
        send_symbol(15'd250, DUR_TOP, 1'b1);
        wait_idle();
    endtask

    // symbol count saturates instead of wrapping
    task automatic test_symbol_saturation();
        write_config(mk_cfg(8, 16, 4, 24, 255));
        repeat (520)
            send_symbol(DUR_TOP, pick_any(), 1'b0);
        send_frame(2, END_ON_BIT, 1'b1);
        wait_idle();
    endtask

    // random frames over a series of register settings
    task automatic test_random_phases();
        jpfr_pkg::cfg_t c;
        int   budget;
        int   nbytes;
        int   r;
        int   t;
        int   s;
        int   l;
        frame_end_t ending;
        for (int p = 0; p < 12; p++)
        begin
            budget = 60;
            case (p)
                0: c = mk_cfg(8, 16, 4, 24, 8);
                1:
                begin
                    c = mk_cfg(1, 255, 0, 24, 0);
                    budget = 15;
                end
                2:
                begin
                    c = mk_cfg(255, 1, 255, DUR_MAX, 255);
                    budget = 25;
                end
                3: c = mk_cfg(1, 20, 1, 100, 3);
                4: c = mk_cfg(8, 16, 4, 1, 0);
                5: c = mk_cfg(10, 30, 5, DUR_MAX, 255);
                default:
                begin
                    t = int'($urandom_range(40, 1));
                    s = int'($urandom_range(100, t));
                    l = s + 2 * t + int'($urandom_range(20, 0));
                    if (l > 255)
                        l = 255;
                    c = mk_cfg(s, l, t,
                               $urandom_range(1) ? int'($urandom_range(300, 20))
                                                 : int'($urandom_range(DUR_MAX, 1)),
                               $urandom_range(3) ? int'($urandom_range(40, 0))
                                                 : int'($urandom_range(255, 0)));
                end
            endcase
            write_config(c);
            // one phase runs without any idle or stall
            idle_en = (p != 5);
            pattern_symbols = 0;
            while (pattern_symbols < budget)
            begin
                r = int'($urandom_range(99));
                nbytes = (r < 60) ? int'($urandom_range(6, 0)) :
                         (r < 90) ? int'($urandom_range(MAX_BYTES, 7)) :
                                    int'($urandom_range(MAX_BYTES + 3, MAX_BYTES + 1));
                r = int'($urandom_range(99));
                ending = (r < 50) ? END_ON_BIT :
                         (r < 70) ? END_TRAILER :
                         (r < 85) ? END_STOP : END_PARTIAL;
                send_frame(nbytes, ending, 1'($urandom_range(1)));
                if ($urandom_range(99) < 4)
                    wait_idle();
            end
            wait_idle();
        end
        idle_en = 1'b1;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            if (expected_records.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                want_rec = expected_records.pop_front();
                check_field("record_kind", int'(rec_ch.record_kind),
                            int'(want_rec.record_kind));
                check_field("data_byte", int'(rec_ch.data_byte), int'(want_rec.data_byte));
                check_field("byte_position", int'(rec_ch.byte_position),
                            int'(want_rec.byte_position));
                check_field("frame_length", int'(rec_ch.frame_length),
                            int'(want_rec.frame_length));
                check_field("frame_accepted", int'(rec_ch.frame_accepted),
                            int'(want_rec.frame_accepted));
                check_field("checksum_ok", int'(rec_ch.checksum_ok),
                            int'(want_rec.checksum_ok));
                check_field("last", int'(rec_ch.last), int'(want_rec.last));
            end
        end
    end

    // output stalls
    always @(posedge clk)
    begin
        rec_ch.ready <= !idle_en || ($urandom_range(99) >= 11);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** j1850_pwm_frame_receiver_core: FAILED **");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sym_ch.valid       = 1'b0;
        sym_ch.high_ticks  = '0;
        sym_ch.low_ticks   = '0;
        sym_ch.last_symbol = 1'b0;
        rec_ch.ready       = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        pattern_symbols    = 0;
        idle_en            = 1'b1;
        cur_cfg = mk_cfg(int'(jpfr_pkg::SHORT_PULSE_RST), int'(jpfr_pkg::LONG_PULSE_RST),
                         int'(jpfr_pkg::TOLERANCE_RST), int'(jpfr_pkg::END_THRESH_RST),
                         int'(jpfr_pkg::MIN_SYMBOLS_RST));
        clear_frame_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_edges();
        test_short_frames();
        test_config_extremes();
        test_random_phases();
        test_symbol_saturation();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_records.size() == 0)
            $display("** j1850_pwm_frame_receiver_core: PASSED **");
        else
            $display("** j1850_pwm_frame_receiver_core: FAILED **");
        $finish;
    end

endmodule
